// ----- hw/rtl/mcalu_pkg.sv -----
// Shared types and opcode constants for the minicomputer ALU condition-code block.
// No dependencies; imported by the execute unit, the top level, the tracker and the bench.
`timescale 1ns / 1ps

package mcalu_pkg;

    // Condition flags, N in the top bit down to C in the bottom bit
    typedef struct packed {
        logic n;
        logic z;
        logic v;
        logic c;
    } alu_flags_t;

    // Everything the execute unit produces for one instruction word
    typedef struct packed {
        logic [15:0] result;
        logic        write_back;
        logic        byte_op;
        alu_flags_t  flags;
        logic        unknown_op;
    } alu_out_t;

    // Opcode bits 15..9 of XOR
    localparam logic [6:0] XOR_CODE = 7'o074;

    // Opcode bits 14..12: operation groups
    localparam logic [2:0] GRP_SINGLE = 3'o0;
    localparam logic [2:0] DOP_MOV    = 3'o1;
    localparam logic [2:0] DOP_CMP    = 3'o2;
    localparam logic [2:0] DOP_BIT    = 3'o3;
    localparam logic [2:0] DOP_BIC    = 3'o4;
    localparam logic [2:0] DOP_BIS    = 3'o5;
    localparam logic [2:0] DOP_ADDSUB = 3'o6;
    localparam logic [2:0] GRP_EXT    = 3'o7;

    // Opcode bits 14..6: single-operand codes
    localparam logic [8:0] SOP_SWAB = 9'o003;
    localparam logic [8:0] SOP_CLR  = 9'o050;
    localparam logic [8:0] SOP_COM  = 9'o051;
    localparam logic [8:0] SOP_INC  = 9'o052;
    localparam logic [8:0] SOP_DEC  = 9'o053;
    localparam logic [8:0] SOP_NEG  = 9'o054;
    localparam logic [8:0] SOP_ADC  = 9'o055;
    localparam logic [8:0] SOP_SBC  = 9'o056;
    localparam logic [8:0] SOP_TST  = 9'o057;
    localparam logic [8:0] SOP_ROR  = 9'o060;
    localparam logic [8:0] SOP_ROL  = 9'o061;
    localparam logic [8:0] SOP_ASR  = 9'o062;
    localparam logic [8:0] SOP_ASL  = 9'o063;
    localparam logic [8:0] SOP_SXT  = 9'o067;

endpackage

// ----- hw/rtl/minicomputer_alu_condition_codes_core.sv -----
// Top level of the minicomputer ALU condition-code block: stream ports, pipeline, flag state.
// Depends on mcalu_pkg and mcalu_exec.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake                    Word contents
//  s_axis    in   s_axis_tvalid/s_axis_tready  opcode, src_value, dst_value
//  m_axis    out  m_axis_tvalid/m_axis_tready  result, write_back, flags; tuser byte/unknown
//
//  One word per cycle sustained while the output is not stalled; a word passes the input
//  register and then the output register before it can leave.
//  The stored N/Z/V/C flags update when a word moves from the input register into the
//  output register, so the next word behind it sees them with no bubble.
//  Reset clears both valid bits and the flags to zero.
//  A stalled output holds its word; the input register still takes one more word.
//  Unknown opcodes pass through with flags reported but not stored.

module minicomputer_alu_condition_codes_core
    import mcalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [15:0] opcode, [31:16] src_value, [47:32] dst_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] result, [16] write_back, [17] flag_n,
                                        // [18] flag_z, [19] flag_v, [20] flag_c, [23:21] zero
    output logic [1:0]  m_axis_tuser    // [0] byte_op, [1] unknown_op
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] opcode_reg;
    logic [15:0] src_reg;
    logic [15:0] dst_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    alu_out_t    out_reg;
    alu_flags_t  flags_reg;
    alu_flags_t  flags_next;
    alu_out_t    exec_out;
    logic        out_free;
    logic        advance;
    logic        accept;

    // Output slot is free when empty or being drained this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mcalu_exec u_exec (
        .opcode    (opcode_reg),
        .src_value (src_reg),
        .dst_value (dst_reg),
        .flags_in  (flags_reg),
        .exec_out  (exec_out)
    );

    always_comb
    begin
        // Input register: fill on accept, drop once its word moves on
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        // Output register: reload whenever free, else hold
        out_valid_next = out_free ? in_valid_reg : out_valid_reg;

        // Flags advance only with a recognized instruction
        flags_next = (advance && !exec_out.unknown_op) ? exec_out.flags : flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg <= s_axis_tdata[15:0];
            src_reg    <= s_axis_tdata[31:16];
            dst_reg    <= s_axis_tdata[47:32];
        end
        if (advance)
            out_reg <= exec_out;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.flags.c, out_reg.flags.v, out_reg.flags.z,
                            out_reg.flags.n, out_reg.write_back, out_reg.result};
    assign m_axis_tuser  = {out_reg.unknown_op, out_reg.byte_op};

endmodule

// ----- hw/rtl/mcalu_exec.sv -----
// Combinational execute unit: decodes one instruction word and computes result and flags.
// Depends on mcalu_pkg.
`timescale 1ns / 1ps

module mcalu_exec
    import mcalu_pkg::*;
(
    input  logic [15:0] opcode,
    input  logic [15:0] src_value,
    input  logic [15:0] dst_value,
    input  alu_flags_t  flags_in,
    output alu_out_t    exec_out
);

    always_comb
    begin
        logic        byte_sel;
        logic        is_xor;
        logic [2:0]  grp;
        logic [8:0]  sop;
        logic [15:0] mask;
        logic [15:0] sgn;
        logic [15:0] smax;
        logic [15:0] s;
        logic [15:0] d;
        logic [15:0] r;
        logic [15:0] res;
        logic [16:0] sum;
        logic        n;
        logic        z;
        logic        v;
        logic        c;
        logic        cin;
        logic        known;
        logic        wb;
        logic        setnz;
        logic        vxor;
        logic        movb;

        is_xor = (opcode[15:9] == XOR_CODE);
        grp    = opcode[14:12];
        sop    = opcode[14:6];

        // SWAB and SXT are word-only; the add/subtract group has no byte form
        byte_sel = opcode[15];
        if (is_xor)
            byte_sel = 1'b0;
        else if (grp == GRP_SINGLE || grp == GRP_EXT)
            byte_sel = opcode[15] && !(sop == SOP_SWAB || sop == SOP_SXT);
        else if (grp == DOP_ADDSUB)
            byte_sel = 1'b0;

        mask = byte_sel ? 16'h00FF : 16'hFFFF;
        sgn  = byte_sel ? 16'h0080 : 16'h8000;
        smax = byte_sel ? 16'h007F : 16'h7FFF;
        s    = src_value & mask;
        d    = dst_value & mask;
        sum  = {1'b0, s} + {1'b0, d};

        n     = flags_in.n;
        z     = flags_in.z;
        v     = flags_in.v;
        c     = flags_in.c;
        cin   = flags_in.c;
        known = 1'b1;
        wb    = 1'b1;
        setnz = 1'b1;
        vxor  = 1'b0;
        movb  = 1'b0;
        r     = '0;

        if (is_xor)
        begin
            r = src_value ^ dst_value;
            v = 1'b0;
        end
        else if (grp != GRP_SINGLE && grp != GRP_EXT)
        begin
            unique case (grp)
                DOP_MOV:
                begin
                    r    = s;
                    v    = 1'b0;
                    movb = byte_sel;
                end
                DOP_CMP:
                begin
                    r  = s - d;
                    wb = 1'b0;
                    v  = |((s ^ d) & (s ^ r) & sgn);
                    c  = (s < d);
                end
                DOP_BIT:
                begin
                    r  = s & d;
                    v  = 1'b0;
                    wb = 1'b0;
                end
                DOP_BIC:
                begin
                    r = ~s & d;
                    v = 1'b0;
                end
                DOP_BIS:
                begin
                    r = s | d;
                    v = 1'b0;
                end
                default:
                begin
                    if (opcode[15])
                    begin
                        r = d - s;
                        v = |((s ^ d) & (d ^ r) & sgn);
                        c = (d < s);
                    end
                    else
                    begin
                        r = sum[15:0];
                        v = |(~(s ^ d) & (s ^ r) & sgn);
                        c = (sum > {1'b0, mask});
                    end
                end
            endcase
        end
        else if (grp == GRP_SINGLE && (!opcode[15] || byte_sel))
        begin
            unique case (sop)
                SOP_CLR:
                begin
                    r = '0;
                    v = 1'b0;
                    c = 1'b0;
                end
                SOP_COM:
                begin
                    r = ~d;
                    v = 1'b0;
                    c = 1'b1;
                end
                SOP_INC:
                begin
                    v = (d == smax);
                    r = d + 16'd1;
                end
                SOP_DEC:
                begin
                    v = (d == sgn);
                    r = d - 16'd1;
                end
                SOP_NEG:
                begin
                    r = (16'd0 - d) & mask;
                    v = (r == sgn);
                    c = (r != 16'd0);
                end
                SOP_ADC:
                begin
                    r = d + {15'd0, cin};
                    c = (d == mask) && cin;
                    v = (d == smax) && cin;
                end
                SOP_SBC:
                begin
                    r = d - {15'd0, cin};
                    c = (d == 16'd0) && cin;
                    v = (d == sgn);
                end
                SOP_TST:
                begin
                    r  = d;
                    v  = 1'b0;
                    c  = 1'b0;
                    wb = 1'b0;
                end
                SOP_ROR:
                begin
                    r    = (d >> 1) | (cin ? sgn : 16'd0);
                    c    = d[0];
                    vxor = 1'b1;
                end
                SOP_ROL:
                begin
                    r    = (d << 1) | {15'd0, cin};
                    c    = |(d & sgn);
                    vxor = 1'b1;
                end
                SOP_ASR:
                begin
                    r    = (d >> 1) | (d & sgn);
                    c    = d[0];
                    vxor = 1'b1;
                end
                SOP_ASL:
                begin
                    r    = d << 1;
                    c    = |(d & sgn);
                    vxor = 1'b1;
                end
                SOP_SWAB:
                begin
                    r     = {d[7:0], d[15:8]};
                    n     = r[7];
                    z     = (r[7:0] == 8'd0);
                    v     = 1'b0;
                    c     = 1'b0;
                    setnz = 1'b0;
                end
                SOP_SXT:
                begin
                    r     = n ? 16'hFFFF : 16'h0000;
                    z     = !n;
                    v     = 1'b0;
                    setnz = 1'b0;
                end
                default:
                    known = 1'b0;
            endcase
        end
        else
        begin
            known = 1'b0;
        end

        res = r & mask;
        if (setnz)
        begin
            n = byte_sel ? res[7] : res[15];
            z = (res == 16'd0);
        end
        if (vxor)
            v = n ^ c;

        if (!known)
        begin
            exec_out.result     = '0;
            exec_out.write_back = 1'b0;
            exec_out.byte_op    = 1'b0;
            exec_out.flags      = flags_in;
            exec_out.unknown_op = 1'b1;
        end
        else
        begin
            if (!byte_sel)
                exec_out.result = res;
            else if (movb)
                exec_out.result = {{8{res[7]}}, res[7:0]};
            else
                exec_out.result = {dst_value[15:8], res[7:0]};
            exec_out.write_back = wb;
            exec_out.byte_op    = byte_sel;
            exec_out.flags      = '{n: n, z: z, v: v, c: c};
            exec_out.unknown_op = 1'b0;
        end
    end

endmodule

// ----- hw/rtl/mcalu_chk.sv -----
// Port-level checker for the minicomputer ALU condition-code block, bound to the top level.
// Depends on minicomputer_alu_condition_codes_core (bind target) only.
`timescale 1ns / 1ps

module mcalu_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic known;
    logic res_zero;

    assign known    = m_axis_tvalid && !m_axis_tuser[1];
    assign res_zero = (m_axis_tdata[7:0] == 8'd0) &&
                      (m_axis_tuser[0] || m_axis_tdata[15:8] == 8'd0);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // Empty output stage must leave the input open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output stage");

    // Unknown opcodes write nothing and carry no result
    a_unknown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
        m_axis_tdata[16:0] == 17'd0 && !m_axis_tuser[0])
        else $error("unknown opcode produced a result or write");

    // Zero result of the operand width always sets Z for a recognized opcode
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        known && res_zero |-> m_axis_tdata[18])
        else $error("zero result without Z flag");

endmodule

bind minicomputer_alu_condition_codes_core mcalu_chk u_mcalu_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/alu_cc_tracker.sv -----
// Result tracker for the minicomputer ALU condition-code block: predicts and compares.
// Depends on mcalu_pkg; watches both stream channels of the block from outside.
`timescale 1ns / 1ps

module alu_cc_tracker
    import mcalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [15:0] opcode, [31:16] src_value, [47:32] dst_value
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [15:0] result, [16] write_back, [17] flag_n,
                                        // [18] flag_z, [19] flag_v, [20] flag_c, [23:21] zero
    input  logic [1:0]  m_axis_tuser,   // [0] byte_op, [1] unknown_op
    output int          mismatches,
    output int          outstanding
);

    alu_flags_t cc_flags;
    alu_out_t   pending_q[$];

    function automatic alu_out_t predict_alu(input logic [15:0] op, input logic [15:0] srcw,
                                             input logic [15:0] dstw);
        alu_out_t    o;
        logic        n, z, v, c, cin, bw, known, wb, setnz, vxor, movb, is_xor;
        logic [2:0]  grp;
        logic [8:0]  sop;
        logic [15:0] m, sb, s, d, r, res;
        logic [16:0] sum;
        n = cc_flags.n;
        z = cc_flags.z;
        v = cc_flags.v;
        c = cc_flags.c;
        cin = c;
        grp = op[14:12];
        sop = op[14:6];
        is_xor = (op[15:9] == XOR_CODE);
        known = 1'b1;
        wb = 1'b1;
        setnz = 1'b1;
        vxor = 1'b0;
        movb = 1'b0;
        r = '0;

        if (is_xor)
            bw = 1'b0;
        else if (grp == GRP_SINGLE || grp == GRP_EXT)
            bw = op[15] && !(sop == SOP_SWAB || sop == SOP_SXT);
        else if (grp == DOP_ADDSUB)
            bw = 1'b0;
        else
            bw = op[15];

        m = bw ? 16'h00ff : 16'hffff;
        sb = bw ? 16'h0080 : 16'h8000;
        s = srcw & m;
        d = dstw & m;

        if (is_xor)
        begin
            r = srcw ^ dstw;
            v = 1'b0;
        end
        else if (grp != GRP_SINGLE && grp != GRP_EXT)
        begin
            case (grp)
                DOP_MOV:
                begin
                    r = s;
                    v = 1'b0;
                    movb = bw;
                end
                DOP_CMP:
                begin
                    r = s - d;
                    wb = 1'b0;
                    v = |((s ^ d) & (s ^ r) & sb);
                    c = s < d;
                end
                DOP_BIT:
                begin
                    r = s & d;
                    v = 1'b0;
                    wb = 1'b0;
                end
                DOP_BIC:
                begin
                    r = ~s & d;
                    v = 1'b0;
                end
                DOP_BIS:
                begin
                    r = s | d;
                    v = 1'b0;
                end
                default:
                begin
                    if (op[15])
                    begin
                        r = d - s;
                        v = |((s ^ d) & (d ^ r) & sb);
                        c = d < s;
                    end
                    else
                    begin
                        sum = {1'b0, s} + {1'b0, d};
                        r = sum[15:0];
                        v = |(~(s ^ d) & (s ^ r) & sb);
                        c = sum > {1'b0, m};
                    end
                end
            endcase
        end
        else if (grp == GRP_SINGLE && (!op[15] || bw))
        begin
            case (sop)
                SOP_CLR:
                begin
                    r = '0;
                    v = 1'b0;
                    c = 1'b0;
                end
                SOP_COM:
                begin
                    r = ~d;
                    v = 1'b0;
                    c = 1'b1;
                end
                SOP_INC:
                begin
                    v = (d == sb - 16'd1);
                    r = d + 16'd1;
                end
                SOP_DEC:
                begin
                    v = (d == sb);
                    r = d - 16'd1;
                end
                SOP_NEG:
                begin
                    r = (16'h0 - d) & m;
                    v = (r == sb);
                    c = (r != 16'h0);
                end
                SOP_ADC:
                begin
                    r = d + {15'h0, cin};
                    c = (d == m) && cin;
                    v = (d == sb - 16'd1) && cin;
                end
                SOP_SBC:
                begin
                    r = d - {15'h0, cin};
                    c = (d == 16'h0) && cin;
                    v = (d == sb);
                end
                SOP_TST:
                begin
                    r = d;
                    v = 1'b0;
                    c = 1'b0;
                    wb = 1'b0;
                end
                SOP_ROR:
                begin
                    r = (d >> 1) | (cin ? sb : 16'h0);
                    c = d[0];
                    vxor = 1'b1;
                end
                SOP_ROL:
                begin
                    r = (d << 1) | {15'h0, cin};
                    c = |(d & sb);
                    vxor = 1'b1;
                end
                SOP_ASR:
                begin
                    c = d[0];
                    r = (d >> 1) | (d & sb);
                    vxor = 1'b1;
                end
                SOP_ASL:
                begin
                    c = |(d & sb);
                    r = d << 1;
                    vxor = 1'b1;
                end
                SOP_SWAB:
                begin
                    r = {d[7:0], d[15:8]};
                    n = r[7];
                    z = (r[7:0] == 8'h0);
                    v = 1'b0;
                    c = 1'b0;
                    setnz = 1'b0;
                end
                SOP_SXT:
                begin
                    r = n ? 16'hffff : 16'h0;
                    z = !n;
                    v = 1'b0;
                    setnz = 1'b0;
                end
                default: known = 1'b0;
            endcase
        end
        else
            known = 1'b0;

        if (!known)
        begin
            // report the stored flags, leave them untouched
            o.result = '0;
            o.write_back = 1'b0;
            o.byte_op = 1'b0;
            o.flags = cc_flags;
            o.unknown_op = 1'b1;
            return o;
        end

        res = r & m;
        if (setnz)
        begin
            n = |(res & sb);
            z = (res == 16'h0);
        end
        if (vxor)
            v = n ^ c;

        if (!bw)
            o.result = res;
        else if (movb)
            o.result = {{8{res[7]}}, res[7:0]};
        else
            o.result = {dstw[15:8], res[7:0]};

        cc_flags.n = n;
        cc_flags.z = z;
        cc_flags.v = v;
        cc_flags.c = c;

        o.write_back = wb;
        o.byte_op = bw;
        o.flags = cc_flags;
        o.unknown_op = 1'b0;
        return o;
    endfunction

    task automatic note_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        alu_out_t want;
        if (!rst_n)
        begin
            cc_flags = '0;
            pending_q.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            // retire first: a word taken in now cannot leave at this same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_q.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none actual %h/%h",
                             $time, m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    note_field("result", want.result, m_axis_tdata[15:0]);
                    note_field("write_back", {15'h0, want.write_back}, {15'h0, m_axis_tdata[16]});
                    note_field("flag_n", {15'h0, want.flags.n}, {15'h0, m_axis_tdata[17]});
                    note_field("flag_z", {15'h0, want.flags.z}, {15'h0, m_axis_tdata[18]});
                    note_field("flag_v", {15'h0, want.flags.v}, {15'h0, m_axis_tdata[19]});
                    note_field("flag_c", {15'h0, want.flags.c}, {15'h0, m_axis_tdata[20]});
                    note_field("pad", 16'h0, {13'h0, m_axis_tdata[23:21]});
                    note_field("byte_op", {15'h0, want.byte_op}, {15'h0, m_axis_tuser[0]});
                    note_field("unknown_op", {15'h0, want.unknown_op}, {15'h0, m_axis_tuser[1]});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_q.insert(pending_q.size(),
                                 predict_alu(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                             s_axis_tdata[47:32]));
            outstanding = pending_q.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Top of the bench for the minicomputer ALU condition-code block: clock, reset, stimulus.
// Depends on mcalu_pkg, the block's top level and alu_cc_tracker for prediction and checks.
`timescale 1ns / 1ps

module tb
    import mcalu_pkg::*;
();

    localparam int  RANDOM_WORDS = 1850;
    localparam int  PHASES       = 4;
    localparam int  HOLD_CYCLES  = 64;      // long receiver hold-off to back the block up
    localparam int  DRAIN_CYCLES = 10;      // margin after the last predicted word has left
    localparam longint RUN_LIMIT = 5_000_000;   // 5 ms, far beyond the slowest clean run
    localparam logic [8:0] SOP_UNUSED = 9'o070; // a single-operand slot with no instruction

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // [15:0] opcode, [31:16] src_value, [47:32] dst_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [15:0] result, [16] write_back, [17] flag_n,
                                        // [18] flag_z, [19] flag_v, [20] flag_c, [23:21] zero
    logic [1:0]  m_axis_tuser;          // [0] byte_op, [1] unknown_op

    int          mismatches;
    int          outstanding;

    // Idle percentages of the current phase, and a one-shot request for a long hold-off
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;

    minicomputer_alu_condition_codes_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    alu_cc_tracker tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops words
    initial
    begin
        #(RUN_LIMIT);
        $display("tb: errors");
        $finish;
    end

    // Receiver: stall at the phase rate; on request hold off for a long stretch once
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one word; entered and left at a falling edge. Valid stays high
    // into the next call so back-to-back words carry no bubble.
    task automatic send_word(input logic [15:0] op, input logic [15:0] src,
                             input logic [15:0] dst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {dst, src, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] sop_word(input logic bw, input logic [8:0] code,
                                             input logic [5:0] dfield);
        return {bw, code, dfield};
    endfunction

    function automatic logic [15:0] dop_word(input logic bw, input logic [2:0] grp,
                                             input logic [11:0] fields);
        return {bw, grp, fields};
    endfunction

    // Operands lean on the sign and carry boundaries of both widths
    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        logic [7:0]  hi;
        hi = 8'($urandom_range(255));
        case ($urandom_range(7))
            0:
            begin
                case ($urandom_range(9))
                    0: v = 16'h0000;
                    1: v = 16'h0001;
                    2: v = 16'h007f;
                    3: v = 16'h0080;
                    4: v = 16'h00ff;
                    5: v = 16'h0100;
                    6: v = 16'h7fff;
                    7: v = 16'h8000;
                    8: v = 16'hfffe;
                    default: v = 16'hffff;
                endcase
            end
            1:
            begin
                case ($urandom_range(4))
                    0: v = {hi, 8'h00};
                    1: v = {hi, 8'h01};
                    2: v = {hi, 8'h7f};
                    3: v = {hi, 8'h80};
                    default: v = {hi, 8'hff};
                endcase
            end
            default: v = 16'($urandom_range(16'hffff));
        endcase
        return v;
    endfunction

    // Mostly decodable instructions with random fields, the rest raw noise
    function automatic logic [15:0] pick_opcode();
        logic [15:0] op;
        logic [8:0]  code;
        logic [2:0]  grp;
        logic [11:0] fields;
        logic [5:0]  dfield;
        logic        bw;
        int          kind;
        kind = $urandom_range(19);
        bw = ($urandom_range(1) == 1);
        fields = 12'($urandom_range(12'hfff));
        dfield = fields[5:0];
        if (kind < 2)
            op = 16'($urandom_range(16'hffff));
        else if (kind < 10)
        begin
            case ($urandom_range(14))
                0:  code = SOP_SWAB;
                1:  code = SOP_CLR;
                2:  code = SOP_COM;
                3:  code = SOP_INC;
                4:  code = SOP_DEC;
                5:  code = SOP_NEG;
                6:  code = SOP_ADC;
                7:  code = SOP_SBC;
                8:  code = SOP_TST;
                9:  code = SOP_ROR;
                10: code = SOP_ROL;
                11: code = SOP_ASR;
                12: code = SOP_ASL;
                13: code = SOP_SXT;
                default: code = SOP_UNUSED;
            endcase
            op = sop_word(bw, code, dfield);
        end
        else if (kind < 18)
        begin
            grp = 3'($urandom_range(6, 1));
            op = dop_word(bw, grp, fields);
        end
        else
        begin
            // XOR, now and then with the byte bit set, which makes it an unknown opcode
            op = {XOR_CODE, fields[8:0]};
            op[15] = ($urandom_range(7) == 0);
        end
        return op;
    endfunction

    initial
    begin : stimulus
        int phase;
        int k;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every operation, both widths, flag corners, the word-only codes
        send_word(sop_word(1'b0, SOP_CLR, 6'o01), 16'h1234, 16'hbeef);
        send_word(sop_word(1'b1, SOP_COM, 6'o02), 16'h0000, 16'h5a00);
        send_word(sop_word(1'b0, SOP_ADC, 6'o03), 16'h0000, 16'hffff);
        send_word(sop_word(1'b0, SOP_INC, 6'o04), 16'h0000, 16'h7fff);
        send_word(sop_word(1'b1, SOP_INC, 6'o05), 16'h0000, 16'h127f);
        send_word(sop_word(1'b0, SOP_DEC, 6'o06), 16'h0000, 16'h8000);
        send_word(sop_word(1'b1, SOP_DEC, 6'o07), 16'h0000, 16'hff80);
        send_word(sop_word(1'b0, SOP_NEG, 6'o10), 16'h0000, 16'h8000);
        send_word(sop_word(1'b1, SOP_NEG, 6'o11), 16'h0000, 16'hab00);
        send_word(sop_word(1'b1, SOP_SBC, 6'o12), 16'h0000, 16'h3400);
        send_word(sop_word(1'b0, SOP_TST, 6'o13), 16'h0000, 16'hffff);
        send_word(sop_word(1'b0, SOP_ROR, 6'o14), 16'h0000, 16'h0001);
        send_word(sop_word(1'b1, SOP_ROL, 6'o15), 16'h0000, 16'h4480);
        send_word(sop_word(1'b0, SOP_ASR, 6'o16), 16'h0000, 16'h8000);
        send_word(sop_word(1'b1, SOP_ASL, 6'o17), 16'h0000, 16'hff40);
        send_word(sop_word(1'b0, SOP_SWAB, 6'o20), 16'h0000, 16'h1280);
        send_word(sop_word(1'b0, SOP_SXT, 6'o21), 16'h0000, 16'h0000);
        // word-only codes with the byte bit set decode as unknown
        send_word(sop_word(1'b1, SOP_SWAB, 6'o22), 16'h0000, 16'h00ff);
        send_word(sop_word(1'b1, SOP_SXT, 6'o23), 16'h0000, 16'h0000);
        send_word(sop_word(1'b0, SOP_UNUSED, 6'o24), 16'hffff, 16'hffff);
        send_word(dop_word(1'b1, DOP_MOV, 12'o0102), 16'h5580, 16'h0000);
        send_word(dop_word(1'b0, DOP_CMP, 12'o0203), 16'h0000, 16'hffff);
        send_word(dop_word(1'b1, DOP_CMP, 12'o0304), 16'h007f, 16'h0080);
        send_word(dop_word(1'b0, DOP_BIT, 12'o0405), 16'hf0f0, 16'h0f0f);
        send_word(dop_word(1'b1, DOP_BIC, 12'o0506), 16'h00ff, 16'hffff);
        send_word(dop_word(1'b0, DOP_BIS, 12'o0607), 16'h8000, 16'h0001);
        send_word(dop_word(1'b0, DOP_ADDSUB, 12'o0710), 16'h7fff, 16'h0001);
        send_word(dop_word(1'b0, DOP_ADDSUB, 12'o1011), 16'hffff, 16'hffff);
        // byte bit on the add/sub code selects a word subtract, dst minus src
        send_word(dop_word(1'b1, DOP_ADDSUB, 12'o1112), 16'h0001, 16'h0000);
        send_word({XOR_CODE, 9'o123}, 16'haaaa, 16'hffff);
        send_word(dop_word(1'b0, GRP_EXT, 12'o5000), 16'h1111, 16'h2222);

        // Random, through each idling phase in turn
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_req = 1'b1;    // keep offering while the output is held off
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct = 7;
                    recv_stall_pct = 7;
                end
            endcase
            for (k = 0; k < RANDOM_WORDS / PHASES; k++)
                send_word(pick_opcode(), pick_operand(), pick_operand());
        end
        s_axis_tvalid = 1'b0;

        // Drain: wait for every predicted word, then a few more cycles
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
